/* rtl/fcskf_pkg.sv */
// Shared constants for the four-channel scalar Kalman filter.
// Widths, reset values and register index codes; no dependencies.
package fcskf_pkg;

	// State entries kept in the filter memory
	localparam int CHANNELS = 4;
	// Sample channels carried by one input beat
	localparam int NUM_IN   = 4;
	localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CHI_W    = $clog2(NUM_IN);

	localparam int SMP_W    = 16;
	localparam int EST_W    = 24;
	localparam int COV_W    = 32;
	localparam int KG_W     = 25;
	localparam int DEN_W    = 33;
	localparam int CGAIN_W  = 16;
	localparam int OFF_W    = 24;
	localparam int CAL_W    = 28;
	localparam int CFG_W    = 32;
	localparam int CFG_IDX_W = 3;

	// Iterative divider: two quotient bits per cycle
	localparam int DIV_Q_W   = 26;
	localparam int DIV_ITERS = DIV_Q_W / 2;
	localparam int DIV_CNT_W = $clog2(DIV_ITERS);

	localparam logic [KG_W-1:0]    Q24_ONE     = 25'h100_0000;
	localparam logic [COV_W-1:0]   COV_RST     = 32'd838861;
	localparam logic [COV_W-1:0]   PNOISE_RST  = 32'd16777;
	localparam logic [COV_W-1:0]   MNOISE_RST  = 32'd16777216;
	localparam logic [CGAIN_W-1:0] GAIN_X_RST  = 16'd7700;
	localparam logic [OFF_W-1:0]   OFF_X_RST   = 24'd21325;
	localparam logic [CGAIN_W-1:0] GAIN_Y_RST  = 16'd7291;
	localparam logic [OFF_W-1:0]   OFF_Y_RST   = 24'd3046;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PNOISE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MNOISE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_X = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OFF_X  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_Y = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OFF_Y  = 3'd5;

	// Channel numbers within one beat
	localparam logic [CHI_W-1:0] CH_X = 2'd0;
	localparam logic [CHI_W-1:0] CH_Y = 2'd1;
	localparam logic [CHI_W-1:0] CH_K = 2'd2;
	localparam logic [CHI_W-1:0] CH_B = 2'd3;

endpackage

/* rtl/fcskf_div.sv */
// Iterative restoring divider for the Kalman gain: (pred << 24) / den.
// Two quotient bits per cycle; depends on fcskf_pkg.
module fcskf_div
	import fcskf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [COV_W-1:0]  pred,
	input  logic [DEN_W-1:0]  den,
	output logic              busy,
	output logic [KG_W-1:0]   quot
);

	logic                 busy_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0]     rem_q;
	logic [DEN_W-1:0]     den_q;
	logic [DIV_Q_W-1:0]   num_q;
	logic [DIV_Q_W-1:0]   quot_q;

	logic [DEN_W-1:0]     rem_nx;
	logic [DIV_Q_W-1:0]   num_nx;
	logic [DIV_Q_W-1:0]   quot_nx;

	always_comb begin
		logic [DEN_W:0]     trial;
		logic [DEN_W-1:0]   r;
		logic [DIV_Q_W-1:0] n;
		logic [DIV_Q_W-1:0] q;
		r = rem_q;
		n = num_q;
		q = quot_q;
		trial = '0;
		for (int i = 0; i < 2; i++) begin
			trial = {r, n[DIV_Q_W-1]};
			n = {n[DIV_Q_W-2:0], 1'b0};
			if (trial >= {1'b0, den_q}) begin
				trial = trial - {1'b0, den_q};
				q = {q[DIV_Q_W-2:0], 1'b1};
			end else begin
				q = {q[DIV_Q_W-2:0], 1'b0};
			end
			r = trial[DEN_W-1:0];
		end
		rem_nx  = r;
		num_nx  = n;
		quot_nx = q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= DIV_CNT_W'(DIV_ITERS - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// The top 30 numerator bits are pred[31:2]; they stay below den
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= {3'b000, pred[COV_W-1:2]};
			num_q  <= {pred[1:0], 24'h00_0000};
			den_q  <= den;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= rem_nx;
			num_q  <= num_nx;
			quot_q <= quot_nx;
		end
	end

	assign busy = busy_q;
	assign quot = quot_q[KG_W-1:0];

endmodule

/* rtl/four_channel_scalar_kalman_filter_top.sv */
// Top level of the four-channel scalar Kalman filter with x/y calibration.
// Depends on fcskf_pkg and fcskf_div.
//
// Input channel: in_valid/in_stall with four signed 16-bit samples per beat.
// Output channel: out_valid/out_stall with value_x/value_y (28-bit Q.8,
// calibrated, saturated) and value_k/value_b (24-bit Q.8 filtered).
// Configuration: cfg_wr_en/cfg_index/cfg_wr_data, write only, while idle.
//
// Channels are filtered one after another. Each channel reads its estimate
// and covariance from a small state memory, runs the gain division on the
// shared divider (two quotient bits per iteration), two multiplies and a
// write-back, plus a calibration step for x and y. out_valid rises in the
// same cycle in which in_stall drops, so a new input beat is taken only
// once the last result has been loaded into the output register.
// The output register holds a finished result while the next item is worked
// on; if the receiver still stalls when the next result is ready, the block
// waits with it and keeps in_stall high.
// Reset loads the register defaults and clears the state valid bits, so every
// channel starts from estimate zero and covariance 0.05; no clearing pass.
module four_channel_scalar_kalman_filter_top
	import fcskf_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [SMP_W-1:0]    sample_x,
	input  logic signed [SMP_W-1:0]    sample_y,
	input  logic signed [SMP_W-1:0]    sample_k,
	input  logic signed [SMP_W-1:0]    sample_b,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [CAL_W-1:0]    value_x,
	output logic signed [CAL_W-1:0]    value_y,
	output logic signed [EST_W-1:0]    value_k,
	output logic signed [EST_W-1:0]    value_b,
	input  logic                       cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_W-1:0]           cfg_wr_data
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RD   = 4'd1;
	localparam logic [3:0] S_PRED = 4'd2;
	localparam logic [3:0] S_DIV  = 4'd3;
	localparam logic [3:0] S_MUL1 = 4'd4;
	localparam logic [3:0] S_MUL2 = 4'd5;
	localparam logic [3:0] S_WB   = 4'd6;
	localparam logic [3:0] S_CAL  = 4'd7;
	localparam logic [3:0] S_OUT  = 4'd8;

	localparam int ST_W  = EST_W + COV_W;
	localparam int P1_W  = KG_W + 1 + EST_W + 1;
	localparam int P2_W  = KG_W + COV_W;
	localparam int CP_W  = CGAIN_W + EST_W;

	localparam logic signed [P1_W-1:0] HALF_P1 = P1_W'(64'd8388608);
	localparam logic [P2_W-1:0]        HALF_P2 = P2_W'(64'd8388608);
	localparam logic signed [CP_W-1:0] HALF_CP = CP_W'(64'd2048);

	function automatic logic signed [EST_W-1:0] sat_est(input logic signed [EST_W+3:0] v);
		logic signed [EST_W+3:0] hi;
		logic signed [EST_W+3:0] lo;
		hi = (EST_W+4)'(28'sh07F_FFFF);
		lo = -(EST_W+4)'(28'sh080_0000);
		if (v > hi) begin
			return 24'sh7F_FFFF;
		end else if (v < lo) begin
			return 24'sh80_0000;
		end
		return v[EST_W-1:0];
	endfunction

	function automatic logic signed [CAL_W-1:0] sat_cal(input logic signed [CAL_W:0] v);
		if (v[CAL_W] != v[CAL_W-1]) begin
			return v[CAL_W] ? {1'b1, {(CAL_W-1){1'b0}}} : {1'b0, {(CAL_W-1){1'b1}}};
		end
		return v[CAL_W-1:0];
	endfunction

	// Control
	logic [3:0]       state_q;
	logic [CHI_W-1:0] ch_q;
	logic             out_valid_q;
	logic             rd_vld_q;
	logic [CHANNELS-1:0] vld_q;

	// Configuration
	logic [COV_W-1:0]   pnoise_q;
	logic [COV_W-1:0]   mnoise_q;
	logic [CGAIN_W-1:0] gain_x_q;
	logic [OFF_W-1:0]   off_x_q;
	logic [CGAIN_W-1:0] gain_y_q;
	logic [OFF_W-1:0]   off_y_q;

	// State memory: {estimate, covariance} per channel
	logic [ST_W-1:0]  st_mem [CHANNELS];
	logic [ST_W-1:0]  rd_word_q;
	logic [CH_W-1:0]  mem_addr;
	logic             rd_en;
	logic             wr_en;

	// Datapath
	logic [SMP_W-1:0]        smp_q [NUM_IN];
	logic [COV_W-1:0]        pred_q;
	logic                    den_zero_q;
	logic signed [EST_W-1:0] est_q;
	logic [KG_W-1:0]         gain_q;
	logic signed [P1_W-1:0]  prod_q;
	logic signed [EST_W-1:0] est_new_q;
	logic [P2_W-1:0]         cprod_q;
	logic signed [CP_W-1:0]  calprod_q;
	logic signed [CAL_W-1:0] res_x_q;
	logic signed [CAL_W-1:0] res_y_q;
	logic signed [EST_W-1:0] res_k_q;
	logic signed [EST_W-1:0] res_b_q;
	logic signed [CAL_W-1:0] value_x_q;
	logic signed [CAL_W-1:0] value_y_q;
	logic signed [EST_W-1:0] value_k_q;
	logic signed [EST_W-1:0] value_b_q;

	logic                    live;
	logic                    last_ch;
	logic                    out_load;
	logic signed [EST_W-1:0] est_cur;
	logic [COV_W-1:0]        cov_cur;
	logic [COV_W:0]          pred_sum;
	logic [COV_W-1:0]        pred_c;
	logic [DEN_W-1:0]        den_c;
	logic [SMP_W-1:0]        smp_cur;
	logic signed [EST_W:0]   diff_c;
	logic signed [P1_W-1:0]  mul1_c;
	logic signed [P1_W-1:0]  rsum_c;
	logic signed [EST_W+2:0] rnd_c;
	logic signed [EST_W+3:0] est_sum_c;
	logic signed [EST_W-1:0] est_new_c;
	logic [KG_W-1:0]         omg_c;
	logic [P2_W-1:0]         mul2_c;
	logic [P2_W-1:0]         csum_c;
	logic [COV_W-1:0]        cov_new_c;
	logic signed [CGAIN_W-1:0] cgain_c;
	logic signed [OFF_W-1:0]   coff_c;
	logic signed [CP_W-1:0]  calmul_c;
	logic signed [CP_W-1:0]  calsum_c;
	logic signed [CAL_W-1:0] calrnd_c;
	logic signed [CAL_W:0]   cal_c;
	logic signed [CAL_W-1:0] cal_sat_c;
	logic                    div_start;
	logic                    div_busy;
	logic [KG_W-1:0]         div_quot;

	assign live     = (32'(ch_q) < CHANNELS);
	assign last_ch  = (ch_q == CHI_W'(NUM_IN - 1));
	assign mem_addr = CH_W'(ch_q);
	assign rd_en    = (state_q == S_RD) && live;
	assign wr_en    = (state_q == S_WB);
	assign out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall);
	assign div_start = (state_q == S_PRED);

	// An entry never written since reset reads as its reset value
	assign est_cur  = rd_vld_q ? $signed(rd_word_q[ST_W-1:COV_W]) : '0;
	assign cov_cur  = rd_vld_q ? rd_word_q[COV_W-1:0] : COV_RST;
	assign pred_sum = {1'b0, cov_cur} + {1'b0, pnoise_q};
	assign pred_c   = pred_sum[COV_W] ? '1 : pred_sum[COV_W-1:0];
	assign den_c    = {1'b0, pred_c} + {1'b0, mnoise_q};

	assign smp_cur  = smp_q[ch_q];
	assign diff_c   = $signed({smp_cur[SMP_W-1], smp_cur, 8'h00})
		- $signed({est_q[EST_W-1], est_q});
	assign mul1_c   = P1_W'($signed({1'b0, gain_q})) * P1_W'(diff_c);

	assign rsum_c    = prod_q + HALF_P1;
	assign rnd_c     = $signed(rsum_c[P1_W-1:24]);
	assign est_sum_c = $signed({{4{est_q[EST_W-1]}}, est_q}) + $signed({rnd_c[EST_W+2], rnd_c});
	assign est_new_c = sat_est(est_sum_c);

	assign omg_c     = Q24_ONE - gain_q;
	assign mul2_c    = P2_W'(omg_c) * P2_W'(pred_q);
	assign csum_c    = cprod_q + HALF_P2;
	assign cov_new_c = csum_c[COV_W+23:24];

	assign cgain_c   = (ch_q == CH_X) ? $signed(gain_x_q) : $signed(gain_y_q);
	assign coff_c    = (ch_q == CH_X) ? $signed(off_x_q) : $signed(off_y_q);
	assign calmul_c  = CP_W'(cgain_c) * CP_W'(est_new_q);
	assign calsum_c  = calprod_q + HALF_CP;
	assign calrnd_c  = $signed(calsum_c[CP_W-1:12]);
	assign cal_c     = $signed({calrnd_c[CAL_W-1], calrnd_c})
		+ $signed({{(CAL_W+1-OFF_W){coff_c[OFF_W-1]}}, coff_c});
	assign cal_sat_c = sat_cal(cal_c);

	fcskf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.pred   (pred_c),
		.den    (den_c),
		.busy   (div_busy),
		.quot   (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ch_q        <= '0;
			out_valid_q <= 1'b0;
			rd_vld_q    <= 1'b0;
			vld_q       <= '0;
			pnoise_q    <= PNOISE_RST;
			mnoise_q    <= MNOISE_RST;
			gain_x_q    <= GAIN_X_RST;
			off_x_q     <= OFF_X_RST;
			gain_y_q    <= GAIN_Y_RST;
			off_y_q     <= OFF_Y_RST;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_PNOISE: pnoise_q <= cfg_wr_data;
					REG_MNOISE: mnoise_q <= cfg_wr_data;
					REG_GAIN_X: gain_x_q <= cfg_wr_data[CGAIN_W-1:0];
					REG_OFF_X:  off_x_q  <= cfg_wr_data[OFF_W-1:0];
					REG_GAIN_Y: gain_y_q <= cfg_wr_data[CGAIN_W-1:0];
					REG_OFF_Y:  off_y_q  <= cfg_wr_data[OFF_W-1:0];
					default: ;
				endcase
			end

			if (rd_en) begin
				rd_vld_q <= vld_q[mem_addr];
			end
			if (wr_en) begin
				vld_q[mem_addr] <= 1'b1;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						ch_q    <= '0;
						state_q <= S_RD;
					end
				end
				S_RD: begin
					if (live) begin
						state_q <= S_PRED;
					end else if (last_ch) begin
						state_q <= S_OUT;
					end else begin
						ch_q <= ch_q + 1'b1;
					end
				end
				S_PRED: state_q <= S_DIV;
				S_DIV: begin
					if (!div_busy) begin
						state_q <= S_MUL1;
					end
				end
				S_MUL1: state_q <= S_MUL2;
				S_MUL2: state_q <= S_WB;
				S_WB: begin
					if (ch_q == CH_X || ch_q == CH_Y) begin
						state_q <= S_CAL;
					end else if (last_ch) begin
						state_q <= S_OUT;
					end else begin
						ch_q    <= ch_q + 1'b1;
						state_q <= S_RD;
					end
				end
				S_CAL: begin
					if (last_ch) begin
						state_q <= S_OUT;
					end else begin
						ch_q    <= ch_q + 1'b1;
						state_q <= S_RD;
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Channels run one after another, so a read never meets a pending write
	// to the same entry.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_word_q <= st_mem[mem_addr];
		end
		if (wr_en) begin
			st_mem[mem_addr] <= {est_new_q, cov_new_c};
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			smp_q[0] <= sample_x;
			smp_q[1] <= sample_y;
			smp_q[2] <= sample_k;
			smp_q[3] <= sample_b;
		end

		if (state_q == S_PRED) begin
			pred_q     <= pred_c;
			den_zero_q <= (den_c == '0);
			est_q      <= est_cur;
		end

		// Zero denominator: gain zero, estimate kept
		if (state_q == S_DIV && !div_busy) begin
			gain_q <= den_zero_q ? '0 : div_quot;
		end

		if (state_q == S_MUL1) begin
			prod_q <= mul1_c;
		end

		if (state_q == S_MUL2) begin
			est_new_q <= est_new_c;
			cprod_q   <= mul2_c;
		end

		if (state_q == S_WB) begin
			calprod_q <= calmul_c;
			case (ch_q)
				CH_K: res_k_q <= est_new_q;
				CH_B: res_b_q <= est_new_q;
				default: ;
			endcase
		end

		if (state_q == S_CAL) begin
			case (ch_q)
				CH_X: res_x_q <= cal_sat_c;
				CH_Y: res_y_q <= cal_sat_c;
				default: ;
			endcase
		end

		// Channels above the state depth give zero
		if (state_q == S_RD && !live) begin
			case (ch_q)
				CH_X: res_x_q <= '0;
				CH_Y: res_y_q <= '0;
				CH_K: res_k_q <= '0;
				CH_B: res_b_q <= '0;
				default: ;
			endcase
		end

		if (out_load) begin
			value_x_q <= res_x_q;
			value_y_q <= res_y_q;
			value_k_q <= res_k_q;
			value_b_q <= res_b_q;
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign value_x   = value_x_q;
	assign value_y   = value_y_q;
	assign value_k   = value_k_q;
	assign value_b   = value_b_q;

endmodule
